// ----- hdl/tir_pkg.sv -----
package tir_pkg;

  localparam int TIR_TABLE_POINTS = 50;
  localparam int E_W    = 32;
  localparam int F_W    = 48;
  localparam int X_W    = 42;
  localparam int IDX_W  = 6;
  localparam int ATT_W  = 17;
  localparam int Q_BITS = 16;
  localparam int QCNT_W = $clog2(Q_BITS);

  localparam logic [ATT_W-1:0] ONE_Q16 = ATT_W'(65536);

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic           go;
    logic [F_W-1:0] num;
    logic [F_W-1:0] den;
  } tir_div_req_t;

  typedef struct packed {
    logic              done;
    logic [Q_BITS-1:0] quo;
  } tir_div_rsp_t;

  // TeV to GeV: e * 1000 = e*1024 - e*16 - e*8
  function automatic logic [X_W-1:0] times_1000(input logic [E_W-1:0] e);
    logic [X_W-1:0] w;
    w = {e, 10'd0} - {6'd0, e, 4'd0} - {7'd0, e, 3'd0};
    return w;
  endfunction

endpackage

// ----- hdl/tir_div.sv -----
module tir_div
  import tir_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  tir_div_req_t req,
  output tir_div_rsp_t rsp
);

  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic [F_W-1:0]    rem_r, rem_nxt;
  logic [F_W-1:0]    den_r, den_nxt;
  logic [Q_BITS-1:0] quo_r, quo_nxt;
  logic [F_W:0]      sh;
  logic [F_W:0]      diff;

  // remainder stays below the divisor, so one shifted bit never overflows
  assign sh   = {rem_r, 1'b0};
  assign diff = sh - {1'b0, den_r};

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (req.go) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      rem_nxt = req.num;
      den_nxt = req.den;
      quo_nxt = '0;
    end else if (run_r) begin
      if (sh >= {1'b0, den_r}) begin
        rem_nxt = diff[F_W-1:0];
        quo_nxt = {quo_r[Q_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = sh[F_W-1:0];
        quo_nxt = {quo_r[Q_BITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == QCNT_W'(Q_BITS - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

// ----- hdl/table_interp_reciprocal_top.sv -----
// Breakpoint table with linear interpolation, answered as 1/factor in Q1.16.
// A load beat (in_func 0) writes one table slot in the cycle it is accepted,
// gives no result and leaves busy low. A query beat walks the table one
// breakpoint per clock from slot 0 (one synchronous memory read each), then
// runs the serial divider for the fraction, a shift-add multiply and, unless
// the factor is at most 1.0 and saturates, the serial divider again for the
// reciprocal. A query below the first breakpoint or above the last one ends
// in the search. Results appear for one cycle on out_valid and cannot be
// stalled; the receiver must take each one.
// Table slots read before being written give undefined results.
module table_interp_reciprocal_top
  import tir_pkg::*;
#(
  parameter int TABLE_POINTS = TIR_TABLE_POINTS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic             in_func,
  input  logic [IDX_W-1:0] in_point_index,
  input  logic [E_W-1:0]   in_point_energy,
  input  logic [F_W-1:0]   in_point_factor,
  input  logic [E_W-1:0]   in_query_energy,
  output logic             out_valid,
  output logic [ATT_W-1:0] out_attenuation,
  output logic             out_below_range,
  output logic             out_above_range
);

  localparam int AW = $clog2(TABLE_POINTS);
  localparam logic [AW-1:0] LAST = AW'(TABLE_POINTS - 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SRCH = 6'b000010,
    S_DIV1 = 6'b000100,
    S_MUL  = 6'b001000,
    S_FAC  = 6'b010000,
    S_DIV2 = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     addr_r, addr_nxt;
  logic [E_W-1:0]    q_r, q_nxt;
  logic [X_W-1:0]    x0_r, x0_nxt;
  logic [F_W-1:0]    y0_r, y0_nxt;
  logic [F_W-1:0]    d_r, d_nxt;
  logic              up_r, up_nxt;
  logic [Q_BITS-1:0] t_r, t_nxt;
  logic [QCNT_W-1:0] mcnt_r, mcnt_nxt;
  logic [63:0]       acc_r, acc_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ATT_W-1:0]  att_r, att_nxt;
  logic              below_r, below_nxt;
  logic              above_r, above_nxt;

  logic [E_W-1:0]    mem_e [TABLE_POINTS];
  logic [F_W-1:0]    mem_f [TABLE_POINTS];
  logic [E_W-1:0]    rd_e_r;
  logic [F_W-1:0]    rd_f_r;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;

  tir_div_req_t      div_req;
  tir_div_rsp_t      div_rsp;

  logic [X_W-1:0]    x_cur;
  logic [X_W-1:0]    q_ext;
  logic [X_W-1:0]    span;
  logic [X_W-1:0]    qoff;
  logic [64:0]       msum;
  logic [F_W-1:0]    prod_hi;
  logic [F_W-1:0]    y_fac;

  assign wr_en   = (state_r == S_IDLE) && start && (in_func == FUNC_LOAD) &&
                   (32'(in_point_index) < TABLE_POINTS);
  assign wr_addr = AW'(in_point_index);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_e[wr_addr] <= in_point_energy;
      mem_f[wr_addr] <= in_point_factor;
    end
    rd_e_r <= mem_e[addr_nxt];
    rd_f_r <= mem_f[addr_nxt];
  end

  assign x_cur   = times_1000(rd_e_r);
  assign q_ext   = {{(X_W - E_W){1'b0}}, q_r};
  assign span    = x_cur - x0_r;
  // previous breakpoint is never above the query, so this fits E_W bits
  assign qoff    = q_ext - x0_r;
  assign msum    = {1'b0, acc_r} + (t_r[0] ? {1'b0, d_r, 16'd0} : 65'd0);
  assign prod_hi = acc_r[63:16];
  assign y_fac   = up_r ? (y0_r + prod_hi) : (y0_r - prod_hi);

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    q_nxt         = q_r;
    x0_nxt        = x0_r;
    y0_nxt        = y0_r;
    d_nxt         = d_r;
    up_nxt        = up_r;
    t_nxt         = t_r;
    mcnt_nxt      = mcnt_r;
    acc_nxt       = acc_r;
    out_valid_nxt = 1'b0;
    att_nxt       = att_r;
    below_nxt     = below_r;
    above_nxt     = above_r;
    div_req.go    = 1'b0;
    div_req.num   = {{(F_W - X_W){1'b0}}, qoff};
    div_req.den   = {{(F_W - X_W){1'b0}}, span};
    case (state_r)
      S_IDLE: begin
        if (start && (in_func == FUNC_QUERY)) begin
          q_nxt     = in_query_energy;
          addr_nxt  = '0;
          state_nxt = S_SRCH;
        end
      end
      S_SRCH: begin
        if (addr_r == '0) begin
          if (q_ext < x_cur) begin
            out_valid_nxt = 1'b1;
            att_nxt       = ONE_Q16;
            below_nxt     = 1'b1;
            above_nxt     = 1'b0;
            state_nxt     = S_IDLE;
          end else begin
            x0_nxt   = x_cur;
            y0_nxt   = rd_f_r;
            addr_nxt = addr_r + 1'b1;
          end
        end else if (x_cur > q_ext) begin
          // bracket found: fraction = qoff * 2^16 / span
          div_req.go = 1'b1;
          up_nxt     = rd_f_r >= y0_r;
          d_nxt      = (rd_f_r >= y0_r) ? (rd_f_r - y0_r) : (y0_r - rd_f_r);
          state_nxt  = S_DIV1;
        end else if (addr_r == LAST) begin
          out_valid_nxt = 1'b1;
          att_nxt       = '0;
          below_nxt     = 1'b0;
          above_nxt     = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          x0_nxt   = x_cur;
          y0_nxt   = rd_f_r;
          addr_nxt = addr_r + 1'b1;
        end
      end
      S_DIV1: begin
        if (div_rsp.done) begin
          t_nxt     = div_rsp.quo;
          acc_nxt   = '0;
          mcnt_nxt  = '0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        // shift-add, multiplier bits lsb first
        acc_nxt  = msum[64:1];
        t_nxt    = {1'b0, t_r[Q_BITS-1:1]};
        mcnt_nxt = mcnt_r + 1'b1;
        if (mcnt_r == QCNT_W'(Q_BITS - 1)) begin
          state_nxt = S_FAC;
        end
      end
      S_FAC: begin
        div_req.num = {{(F_W - ATT_W){1'b0}}, ONE_Q16};
        div_req.den = y_fac;
        if (y_fac <= {{(F_W - ATT_W){1'b0}}, ONE_Q16}) begin
          // factor at most 1.0 (zero too) saturates
          out_valid_nxt = 1'b1;
          att_nxt       = ONE_Q16;
          below_nxt     = 1'b0;
          above_nxt     = 1'b0;
          state_nxt     = S_IDLE;
        end else begin
          div_req.go = 1'b1;
          state_nxt  = S_DIV2;
        end
      end
      S_DIV2: begin
        if (div_rsp.done) begin
          out_valid_nxt = 1'b1;
          att_nxt       = {1'b0, div_rsp.quo};
          below_nxt     = 1'b0;
          above_nxt     = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      addr_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      addr_r      <= addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r     <= q_nxt;
    x0_r    <= x0_nxt;
    y0_r    <= y0_nxt;
    d_r     <= d_nxt;
    up_r    <= up_nxt;
    t_r     <= t_nxt;
    mcnt_r  <= mcnt_nxt;
    acc_r   <= acc_nxt;
    att_r   <= att_nxt;
    below_r <= below_nxt;
    above_r <= above_nxt;
  end

  tir_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_attenuation = att_r;
  assign out_below_range = below_r;
  assign out_above_range = above_r;

endmodule
